>>> rtl/stb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg
// Types, codes and character classes shared by the source tokenizer files.
// ----------------------------------------------------------------------------
package stb_pkg;

	// scanner mode
	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_COMMENT,
		MODE_WORD,
		MODE_INT,
		MODE_FRAC,
		MODE_STRING,
		MODE_NEWLINE,
		MODE_DONE
	} mode_t;

	// result kinds
	localparam logic [1:0] KIND_TEXT = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// token types
	localparam logic [2:0] TYPE_WORD    = 3'd0;
	localparam logic [2:0] TYPE_NUMBER  = 3'd1;
	localparam logic [2:0] TYPE_STRING  = 3'd2;
	localparam logic [2:0] TYPE_NEWLINE = 3'd3;
	localparam logic [2:0] TYPE_EOF     = 3'd4;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_UNEXP    = 2'd1;
	localparam logic [1:0] ERR_UNTERM   = 2'd2;

	// input ops
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	// characters
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	localparam logic [15:0] POS_MAX = 16'hFFFF;

	// command queue geometry
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	// one result word, without the last marker
	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  tok_type;
		logic [7:0]  text_byte;
		logic [5:0]  length;
		logic [15:0] line;
		logic [15:0] column;
		logic [1:0]  err_code;
	} res_t;

	// one queue entry: the one or two results of an input word
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} cmd_t;

	// queue to back end
	typedef struct packed {
		logic empty;
		cmd_t head;
	} q_stat_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
	endfunction

	function automatic logic is_numeral(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_FF;
	endfunction

endpackage

>>> rtl/stb_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_in_if
// Source byte channel: valid/ready plus op and byte.
// ----------------------------------------------------------------------------
interface stb_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] ch;

	modport source (output valid, output op, output ch, input ready);
	modport sink (input valid, input op, input ch, output ready);
endinterface

>>> rtl/stb_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_out_if
// Token result channel: valid/ready plus the result fields.
// ----------------------------------------------------------------------------
interface stb_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  tok_type;
	logic [7:0]  text_byte;
	logic [5:0]  length;
	logic [15:0] line;
	logic [15:0] column;
	logic [1:0]  err_code;
	logic        last;

	modport source (output valid, output kind, output tok_type, output text_byte,
		output length, output line, output column, output err_code, output last,
		input ready);
	modport sink (input valid, input kind, input tok_type, input text_byte,
		input length, input line, input column, input err_code, input last,
		output ready);
endinterface

>>> rtl/stb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_front
// Scanner state machine: takes one source word, updates position and mode,
// and pushes the one or two results it causes as one queue entry.
// ----------------------------------------------------------------------------
module stb_front #(
	parameter int MAX_TOKEN_LEN = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	stb_in_if.sink           src,
	input  logic             q_full,
	output logic             push,
	output stb_pkg::cmd_t    push_cmd
);

	stb_pkg::mode_t mode_q, mode_d;
	logic [5:0]     tok_len_q, tok_len_d;
	logic [15:0]    start_line_q, start_line_d, start_col_q, start_col_d;
	logic [15:0]    cur_line_q, cur_line_d, cur_col_q, cur_col_d;
	logic           halted_q, halted_d;

	logic           accept, room, close, idle, a_v, b_v;
	stb_pkg::res_t  a, b;
	logic [2:0]     pend_type;
	logic [7:0]     c;

	assign src.ready = !q_full;
	assign accept    = src.valid && src.ready;
	assign c         = src.ch;
	assign room      = tok_len_q < 6'(MAX_TOKEN_LEN - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= stb_pkg::MODE_IDLE;
			tok_len_q    <= '0;
			start_line_q <= 16'd1;
			start_col_q  <= 16'd1;
			cur_line_q   <= 16'd1;
			cur_col_q    <= 16'd1;
			halted_q     <= 1'b0;
		end else if (accept) begin
			mode_q       <= mode_d;
			tok_len_q    <= tok_len_d;
			start_line_q <= start_line_d;
			start_col_q  <= start_col_d;
			cur_line_q   <= cur_line_d;
			cur_col_q    <= cur_col_d;
			halted_q     <= halted_d;
		end
	end

	always_comb begin
		mode_d       = mode_q;
		tok_len_d    = tok_len_q;
		start_line_d = start_line_q;
		start_col_d  = start_col_q;
		cur_line_d   = cur_line_q;
		cur_col_d    = cur_col_q;
		halted_d     = halted_q;
		close        = 1'b0;
		idle         = 1'b0;
		a_v          = 1'b0;
		b_v          = 1'b0;
		a            = '0;
		b            = '0;

		unique case (mode_q)
			stb_pkg::MODE_WORD:    pend_type = stb_pkg::TYPE_WORD;
			stb_pkg::MODE_NEWLINE: pend_type = stb_pkg::TYPE_NEWLINE;
			default:               pend_type = stb_pkg::TYPE_NUMBER;
		endcase

		if (!halted_q && mode_q != stb_pkg::MODE_DONE) begin
			if (src.op == stb_pkg::OP_END) begin
				if (mode_q == stb_pkg::MODE_STRING) begin
					halted_d   = 1'b1;
					b_v        = 1'b1;
					b.kind     = stb_pkg::KIND_ERR;
					b.line     = start_line_q;
					b.column   = start_col_q;
					b.err_code = stb_pkg::ERR_UNTERM;
				end else begin
					close      = mode_q inside {stb_pkg::MODE_WORD, stb_pkg::MODE_INT,
						stb_pkg::MODE_FRAC, stb_pkg::MODE_NEWLINE};
					b_v        = 1'b1;
					b.kind     = stb_pkg::KIND_END;
					b.tok_type = stb_pkg::TYPE_EOF;
					b.line     = cur_line_q;
					b.column   = cur_col_q;
					mode_d     = stb_pkg::MODE_DONE;
				end
			end else begin
				// text-byte template for appends
				b.kind      = stb_pkg::KIND_TEXT;
				b.text_byte = c;
				b.line      = start_line_q;
				b.column    = start_col_q;
				unique case (mode_q)
					stb_pkg::MODE_COMMENT: begin
						idle = (c == stb_pkg::CH_NL);
					end
					stb_pkg::MODE_WORD: begin
						if (room && (stb_pkg::is_letter(c) || stb_pkg::is_numeral(c))) begin
							b_v        = 1'b1;
							b.tok_type = stb_pkg::TYPE_WORD;
							tok_len_d  = tok_len_q + 6'd1;
						end else begin
							close = 1'b1;
							idle  = 1'b1;
						end
					end
					stb_pkg::MODE_INT: begin
						if (room && stb_pkg::is_numeral(c)) begin
							b_v        = 1'b1;
							b.tok_type = stb_pkg::TYPE_NUMBER;
							tok_len_d  = tok_len_q + 6'd1;
						end else if (room && c == stb_pkg::CH_DOT) begin
							b_v        = 1'b1;
							b.tok_type = stb_pkg::TYPE_NUMBER;
							tok_len_d  = tok_len_q + 6'd1;
							mode_d     = stb_pkg::MODE_FRAC;
						end else begin
							close = 1'b1;
							idle  = 1'b1;
						end
					end
					stb_pkg::MODE_FRAC: begin
						if (room && stb_pkg::is_numeral(c)) begin
							b_v        = 1'b1;
							b.tok_type = stb_pkg::TYPE_NUMBER;
							tok_len_d  = tok_len_q + 6'd1;
						end else begin
							close = 1'b1;
							idle  = 1'b1;
						end
					end
					stb_pkg::MODE_NEWLINE: begin
						close = 1'b1;
						idle  = 1'b1;
					end
					stb_pkg::MODE_STRING: begin
						if (c == stb_pkg::CH_QUOTE) begin
							b_v         = 1'b1;
							b.kind      = stb_pkg::KIND_END;
							b.tok_type  = stb_pkg::TYPE_STRING;
							b.text_byte = '0;
							b.length    = tok_len_q;
							mode_d      = stb_pkg::MODE_IDLE;
						end else if (c == stb_pkg::CH_NL || !room) begin
							halted_d    = 1'b1;
							b_v         = 1'b1;
							b.kind      = stb_pkg::KIND_ERR;
							b.text_byte = '0;
							b.err_code  = stb_pkg::ERR_UNTERM;
						end else begin
							b_v        = 1'b1;
							b.tok_type = stb_pkg::TYPE_STRING;
							tok_len_d  = tok_len_q + 6'd1;
						end
					end
					default: begin
						idle = 1'b1;
					end
				endcase

				// a byte between tokens
				if (idle) begin
					b            = '0;
					mode_d       = stb_pkg::MODE_IDLE;
					if (stb_pkg::is_blank(c)) begin
						mode_d = stb_pkg::MODE_IDLE;
					end else if (c == stb_pkg::CH_HASH) begin
						mode_d = stb_pkg::MODE_COMMENT;
					end else if (c == stb_pkg::CH_NL || stb_pkg::is_letter(c) ||
							stb_pkg::is_numeral(c)) begin
						start_line_d = cur_line_q;
						start_col_d  = cur_col_q;
						tok_len_d    = 6'd1;
						b_v          = 1'b1;
						b.kind       = stb_pkg::KIND_TEXT;
						b.text_byte  = c;
						b.line       = cur_line_q;
						b.column     = cur_col_q;
						if (c == stb_pkg::CH_NL) begin
							mode_d     = stb_pkg::MODE_NEWLINE;
							b.tok_type = stb_pkg::TYPE_NEWLINE;
						end else if (stb_pkg::is_letter(c)) begin
							mode_d     = stb_pkg::MODE_WORD;
							b.tok_type = stb_pkg::TYPE_WORD;
						end else begin
							mode_d     = stb_pkg::MODE_INT;
							b.tok_type = stb_pkg::TYPE_NUMBER;
						end
					end else if (c == stb_pkg::CH_QUOTE) begin
						start_line_d = cur_line_q;
						start_col_d  = cur_col_q;
						tok_len_d    = '0;
						mode_d       = stb_pkg::MODE_STRING;
					end else begin
						halted_d   = 1'b1;
						b_v        = 1'b1;
						b.kind     = stb_pkg::KIND_ERR;
						b.line     = cur_line_q;
						b.column   = cur_col_q;
						b.err_code = stb_pkg::ERR_UNEXP;
					end
				end

				// position advance, saturating
				if (c == stb_pkg::CH_NL) begin
					if (cur_line_q != stb_pkg::POS_MAX) cur_line_d = cur_line_q + 16'd1;
					cur_col_d = 16'd1;
				end else if (cur_col_q != stb_pkg::POS_MAX) begin
					cur_col_d = cur_col_q + 16'd1;
				end
			end

			// pending word/number/newline end goes out first
			if (close) begin
				a_v        = 1'b1;
				a.kind     = stb_pkg::KIND_END;
				a.tok_type = pend_type;
				a.length   = tok_len_q;
				a.line     = start_line_q;
				a.column   = start_col_q;
			end
		end

		push = accept && (a_v || b_v);
		if (a_v) begin
			push_cmd.two = b_v;
			push_cmd.r0  = a;
			push_cmd.r1  = b;
		end else begin
			push_cmd.two = 1'b0;
			push_cmd.r0  = b;
			push_cmd.r1  = '0;
		end
	end

endmodule

>>> rtl/stb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_queue
// Small FIFO of result entries between scanner and output sequencer.
// ----------------------------------------------------------------------------
module stb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  stb_pkg::cmd_t     push_cmd,
	input  logic              pop,
	output logic              full,
	output stb_pkg::q_stat_t  stat
);

	stb_pkg::cmd_t              mem_q [stb_pkg::QDEPTH];
	logic [stb_pkg::QAW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [stb_pkg::QAW:0]      count_q;
	logic                       do_pop;

	assign full       = count_q == (stb_pkg::QAW + 1)'(stb_pkg::QDEPTH);
	assign stat.empty = count_q == '0;
	assign stat.head  = mem_q[rd_ptr_q];
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + (stb_pkg::QAW)'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + (stb_pkg::QAW)'(1);
			count_q <= count_q + (stb_pkg::QAW + 1)'(push) - (stb_pkg::QAW + 1)'(do_pop);
		end
	end

endmodule

>>> rtl/stb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_back
// Output sequencer: unpacks queue entries into result words, holding the
// second result of a pair, behind a registered output.
// ----------------------------------------------------------------------------
module stb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  stb_pkg::q_stat_t  stat,
	output logic              pop,
	stb_out_if.source         tok
);

	stb_pkg::res_t out_q, pend_q;
	logic          last_q, valid_q, pend_v_q;
	logic          load;

	assign load = !valid_q || tok.ready;
	assign pop  = load && !pend_v_q && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (load) begin
			if (pend_v_q) begin
				valid_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end else begin
				valid_q  <= !stat.empty;
				pend_v_q <= !stat.empty && stat.head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_v_q) begin
				out_q  <= pend_q;
				last_q <= 1'b1;
			end else begin
				out_q  <= stat.head.r0;
				last_q <= !stat.head.two;
				pend_q <= stat.head.r1;
			end
		end
	end

	assign tok.valid     = valid_q;
	assign tok.kind      = out_q.kind;
	assign tok.tok_type  = out_q.tok_type;
	assign tok.text_byte = out_q.text_byte;
	assign tok.length    = out_q.length;
	assign tok.line      = out_q.line;
	assign tok.column    = out_q.column;
	assign tok.err_code  = out_q.err_code;
	assign tok.last      = last_q;

endmodule

>>> rtl/source_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexical scanner: source bytes in, token text / token end / error
// words out, with saturating line and column tracking.
// ----------------------------------------------------------------------------
//
//  channel | dir | word                       | accepted when
//  --------+-----+----------------------------+----------------------
//  src     | in  | op, ch                     | src.valid && src.ready
//  tok     | out | kind, tok_type, text_byte, | tok.valid && tok.ready
//          |     | length, line, column,      |
//          |     | err_code, last             |
//
//  One source word per cycle while the queue has room. The scanner state
//  machine in the front end sets that figure: it updates mode and position in
//  the cycle it takes a word. A word causes zero, one or two results; the
//  output sequencer sends one result per cycle while tok is ready, so a pair
//  goes out as two result words. A result is held in a queue entry and then
//  in the output register before it can be taken at tok.
//  src.ready drops only while the four-entry queue is full; tok stalls fill
//  the queue, and the scanner keeps taking words until it is full.
//  Reset is asynchronous (arst_n low) and clears mode, position, halt flag,
//  queue pointers and output valid; no clearing pass is needed.
//
module source_tokenizer #(
	parameter int MAX_TOKEN_LEN = 64  // text cap is MAX_TOKEN_LEN-1 bytes, 2..64
) (
	input  logic      clk,
	input  logic      arst_n,
	stb_in_if.sink    src,
	stb_out_if.source tok
);

	logic              push, pop, q_full;
	stb_pkg::cmd_t     push_cmd;
	stb_pkg::q_stat_t  q_stat;

	// front end: classify each byte, track position, form results
	stb_front #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src      (src),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// decoupling queue; one entry per word that causes any result
	stb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.stat     (q_stat)
	);

	// back end: one result word per cycle while tok is ready, last set on the final one
	stb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (q_stat),
		.pop    (pop),
		.tok    (tok)
	);

endmodule

>>> tb/source_tokenizer_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer_chk
// Watches both channels of the tokenizer, scans each accepted source word with
// its own lexer state and compares every token word against the oldest one due.
// ----------------------------------------------------------------------------
module source_tokenizer_chk #(
	parameter int MAX_LEN = 64
) (
	input  logic clk,
	input  logic arst_n,
	stb_in_if    src,
	stb_out_if   tok,
	output int   fails,
	output int   due
);

	localparam logic [2:0] TYPE_NONE = 3'd0;

	typedef struct packed {
		stb_pkg::res_t r;
		logic          last;
	} tok_word_t;

	// lexer state
	stb_pkg::mode_t md    = stb_pkg::MODE_IDLE;
	logic [5:0]     tlen  = '0;
	logic [15:0]    sline = 16'd1;
	logic [15:0]    scol  = 16'd1;
	logic [15:0]    cline = 16'd1;
	logic [15:0]    ccol  = 16'd1;
	logic           halt  = 1'b0;

	stb_pkg::res_t step_buf[$];
	tok_word_t     tokens_due[$];
	tok_word_t     head;
	int            fail_cnt = 0;
	int            seen = 0;

	assign fails = fail_cnt;

	function automatic logic is_alpha_ch(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			c == stb_pkg::CH_UNDER;
	endfunction

	function automatic logic is_dec_ch(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_gap_ch(logic [7:0] c);
		return c == stb_pkg::CH_SPACE || c == stb_pkg::CH_TAB || c == stb_pkg::CH_CR ||
			c == stb_pkg::CH_FF;
	endfunction

	function automatic void emit(logic [1:0] k, logic [2:0] ty, logic [7:0] b, logic [5:0] len,
		logic [15:0] ln, logic [15:0] col, logic [1:0] e);
		stb_pkg::res_t r;
		r.kind      = k;
		r.tok_type  = ty;
		r.text_byte = b;
		r.length    = len;
		r.line      = ln;
		r.column    = col;
		r.err_code  = e;
		step_buf.push_back(r);
	endfunction

	function automatic void close_tok();
		logic [2:0] ty;
		ty = (md == stb_pkg::MODE_WORD) ? stb_pkg::TYPE_WORD :
			(md == stb_pkg::MODE_NEWLINE) ? stb_pkg::TYPE_NEWLINE : stb_pkg::TYPE_NUMBER;
		emit(stb_pkg::KIND_END, ty, 8'h00, tlen, sline, scol, stb_pkg::ERR_NONE);
		md = stb_pkg::MODE_IDLE;
	endfunction

	function automatic void open_tok(stb_pkg::mode_t m, logic [2:0] ty, logic [7:0] c);
		sline = cline;
		scol  = ccol;
		tlen  = 6'd1;
		md    = m;
		emit(stb_pkg::KIND_TEXT, ty, c, 6'd0, sline, scol, stb_pkg::ERR_NONE);
	endfunction

	function automatic void grow_tok(logic [2:0] ty, logic [7:0] c);
		tlen = tlen + 6'd1;
		emit(stb_pkg::KIND_TEXT, ty, c, 6'd0, sline, scol, stb_pkg::ERR_NONE);
	endfunction

	// byte seen between tokens
	function automatic void scan_idle(logic [7:0] c);
		md = stb_pkg::MODE_IDLE;
		if (is_gap_ch(c)) begin
			return;
		end
		if (c == stb_pkg::CH_HASH) begin
			md = stb_pkg::MODE_COMMENT;
		end else if (c == stb_pkg::CH_NL) begin
			open_tok(stb_pkg::MODE_NEWLINE, stb_pkg::TYPE_NEWLINE, c);
		end else if (is_alpha_ch(c)) begin
			open_tok(stb_pkg::MODE_WORD, stb_pkg::TYPE_WORD, c);
		end else if (is_dec_ch(c)) begin
			open_tok(stb_pkg::MODE_INT, stb_pkg::TYPE_NUMBER, c);
		end else if (c == stb_pkg::CH_QUOTE) begin
			sline = cline;
			scol  = ccol;
			tlen  = 6'd0;
			md    = stb_pkg::MODE_STRING;
		end else begin
			halt = 1'b1;
			emit(stb_pkg::KIND_ERR, TYPE_NONE, 8'h00, 6'd0, cline, ccol, stb_pkg::ERR_UNEXP);
		end
	endfunction

	task automatic lex_step(input logic op, input logic [7:0] c);
		logic      room;
		tok_word_t w;
		room = (int'(tlen) < MAX_LEN - 1);
		step_buf.delete();
		if (halt || md == stb_pkg::MODE_DONE) begin
			return;
		end
		if (op == stb_pkg::OP_END) begin
			if (md == stb_pkg::MODE_STRING) begin
				halt = 1'b1;
				emit(stb_pkg::KIND_ERR, TYPE_NONE, 8'h00, 6'd0, sline, scol,
					stb_pkg::ERR_UNTERM);
			end else begin
				if (md == stb_pkg::MODE_WORD || md == stb_pkg::MODE_INT ||
						md == stb_pkg::MODE_FRAC || md == stb_pkg::MODE_NEWLINE)
					close_tok();
				emit(stb_pkg::KIND_END, stb_pkg::TYPE_EOF, 8'h00, 6'd0, cline, ccol,
					stb_pkg::ERR_NONE);
				md = stb_pkg::MODE_DONE;
			end
		end else begin
			case (md)
				stb_pkg::MODE_COMMENT: begin
					if (c == stb_pkg::CH_NL) scan_idle(c);
				end
				stb_pkg::MODE_WORD: begin
					if (room && (is_alpha_ch(c) || is_dec_ch(c))) begin
						grow_tok(stb_pkg::TYPE_WORD, c);
					end else begin
						close_tok();
						scan_idle(c);
					end
				end
				stb_pkg::MODE_INT: begin
					if (room && is_dec_ch(c)) begin
						grow_tok(stb_pkg::TYPE_NUMBER, c);
					end else if (room && c == stb_pkg::CH_DOT) begin
						grow_tok(stb_pkg::TYPE_NUMBER, c);
						md = stb_pkg::MODE_FRAC;
					end else begin
						close_tok();
						scan_idle(c);
					end
				end
				stb_pkg::MODE_FRAC: begin
					if (room && is_dec_ch(c)) begin
						grow_tok(stb_pkg::TYPE_NUMBER, c);
					end else begin
						close_tok();
						scan_idle(c);
					end
				end
				stb_pkg::MODE_NEWLINE: begin
					close_tok();
					scan_idle(c);
				end
				stb_pkg::MODE_STRING: begin
					if (c == stb_pkg::CH_QUOTE) begin
						emit(stb_pkg::KIND_END, stb_pkg::TYPE_STRING, 8'h00, tlen, sline, scol,
							stb_pkg::ERR_NONE);
						md = stb_pkg::MODE_IDLE;
					end else if (c == stb_pkg::CH_NL || !room) begin
						halt = 1'b1;
						emit(stb_pkg::KIND_ERR, TYPE_NONE, 8'h00, 6'd0, sline, scol,
							stb_pkg::ERR_UNTERM);
					end else begin
						grow_tok(stb_pkg::TYPE_STRING, c);
					end
				end
				default: begin
					scan_idle(c);
				end
			endcase
			// saturating position
			if (c == stb_pkg::CH_NL) begin
				if (cline != stb_pkg::POS_MAX) cline = cline + 16'd1;
				ccol = 16'd1;
			end else if (ccol != stb_pkg::POS_MAX) begin
				ccol = ccol + 16'd1;
			end
		end
		foreach (step_buf[i]) begin
			w.r    = step_buf[i];
			w.last = (i == step_buf.size() - 1);
			tokens_due.push_back(w);
		end
	endtask

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		fail_cnt++;
		$display("%0t: tok word %0d: %s got %0h want %0h", $time, seen, what, got, want);
	endtask

	task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
		if (got !== want) report(what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			md    = stb_pkg::MODE_IDLE;
			tlen  = '0;
			sline = 16'd1;
			scol  = 16'd1;
			cline = 16'd1;
			ccol  = 16'd1;
			halt  = 1'b0;
			tokens_due.delete();
			due <= 0;
		end else begin
			if (src.valid && src.ready) lex_step(src.op, src.ch);
			if (tok.valid && tok.ready) begin
				seen++;
				if (tokens_due.size() == 0) begin
					report("word with none due, kind", 16'(tok.kind), 16'd0);
				end else begin
					head = tokens_due.pop_front();
					check_field("kind", 16'(tok.kind), 16'(head.r.kind));
					check_field("tok_type", 16'(tok.tok_type), 16'(head.r.tok_type));
					check_field("text_byte", 16'(tok.text_byte), 16'(head.r.text_byte));
					check_field("length", 16'(tok.length), 16'(head.r.length));
					check_field("line", tok.line, head.r.line);
					check_field("column", tok.column, head.r.column);
					check_field("err_code", 16'(tok.err_code), 16'(head.r.err_code));
					check_field("last", 16'(tok.last), 16'(head.last));
				end
			end
			due <= tokens_due.size();
		end
	end

endmodule

>>> tb/source_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer_tb
// Feeds the tokenizer a stream of well-formed source text with random content:
// a short opening run of edge characters, random tokens with random idle gaps
// on both channels, full-rate runs of blanks and newlines, and one random
// ending (end of file or a halting error). The checker beside the block does
// the prediction; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module source_tokenizer_tb;

	localparam int TOK_CAP      = 64;
	localparam int RAND_WORDS   = 1300;   // source words in the random part
	localparam int SAT_RUN      = 24;     // length of each full-rate run
	localparam int MAX_GAP      = 17;
	localparam int HOLD_CYCLES  = 400;    // long sink hold-off, fills the queue
	localparam int IDLE_LIMIT   = 2000;   // cycles with no word moving on either side
	localparam int DRAIN_CYCLES = 32;

	// how the source text is brought to a close; only one per run, since
	// the block ignores everything after end of file or an error until reset
	typedef enum logic [2:0] {
		END_BARE,        // end of file between tokens
		END_AFTER_WORD,  // pending word end, then end of file
		END_AFTER_NL,    // pending newline end, then end of file
		END_STRAY,       // unexpected character, maybe after a pending word
		END_SECOND_DOT,  // number with two dots
		END_STR_NL,      // newline inside a string
		END_STR_EOF,     // end of file inside a string
		END_STR_CAP      // string longer than the text cap
	} ending_t;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_cnt;
	int   due_cnt;
	int   sent = 0;
	bit   rush = 1'b0;       // both sides run without gaps
	bit   src_quiet = 1'b0;  // source side runs without gaps for a stretch

	logic [7:0] blanks [$] = '{stb_pkg::CH_SPACE, stb_pkg::CH_TAB, stb_pkg::CH_CR,
		stb_pkg::CH_FF};
	logic [7:0] strays [$] = '{8'h00, 8'h21, 8'h24, 8'h40, 8'h2C, 8'h7E, 8'h7F, 8'h80,
		8'hFF, stb_pkg::CH_DOT};

	// opening run: a word with every letter/digit edge, each blank, a number
	// with a fraction, a string holding bytes 0 and 255, a comment up to a
	// newline, an empty string and a trailing newline
	logic [7:0] opening [$] = '{
		stb_pkg::CH_UNDER, 8'h7A, 8'h41, 8'h5A, 8'h61, 8'h30, 8'h39, stb_pkg::CH_SPACE,
		stb_pkg::CH_TAB, stb_pkg::CH_CR, stb_pkg::CH_FF,
		8'h31, stb_pkg::CH_DOT, 8'h39, stb_pkg::CH_SPACE,
		stb_pkg::CH_QUOTE, 8'h00, 8'hFF, stb_pkg::CH_QUOTE,
		stb_pkg::CH_HASH, 8'hFF, stb_pkg::CH_NL,
		stb_pkg::CH_QUOTE, stb_pkg::CH_QUOTE,
		stb_pkg::CH_NL
	};

	stb_in_if  src ();
	stb_out_if tok ();

	source_tokenizer #(
		.MAX_TOKEN_LEN(TOK_CAP)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.tok    (tok)
	);

	source_tokenizer_chk #(
		.MAX_LEN(TOK_CAP)
	) i_chk (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.tok    (tok),
		.fails  (fail_cnt),
		.due    (due_cnt)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---- character pickers ------------------------------------------------

	function automatic logic [7:0] pick_letter();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26) return 8'h61 + 8'(r);       // a..z
		if (r < 52) return 8'h41 + 8'(r - 26);  // A..Z
		return stb_pkg::CH_UNDER;
	endfunction

	function automatic logic [7:0] pick_alnum();
		int r;
		r = $urandom_range(0, 62);
		if (r < 53) return pick_letter();
		return 8'h30 + 8'(r - 53);              // 0..9
	endfunction

	function automatic logic [7:0] pick_digit();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_blank();
		return blanks[$urandom_range(0, blanks.size() - 1)];
	endfunction

	// any byte but newline; inside a string the quote is kept out too
	function automatic logic [7:0] pick_free(bit in_string);
		logic [7:0] c;
		do c = 8'($urandom);
		while (c == stb_pkg::CH_NL || (in_string && c == stb_pkg::CH_QUOTE));
		return c;
	endfunction

	// ---- source channel -----------------------------------------------------

	// One source word: optional idle gap, then hold valid until ready. valid
	// stays high across back-to-back words so it is never dropped and raised
	// in the same step.
	task automatic offer(input logic op, input logic [7:0] c);
		int gap;
		gap = (rush || src_quiet) ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			src.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src.valid <= 1'b1;
		src.op    <= op;
		src.ch    <= c;
		@(posedge clk);
		while (!src.ready) @(posedge clk);
		sent++;
		if (sent % 40 == 0) src_quiet = ($urandom_range(0, 3) == 0);
	endtask

	task automatic feed(input logic [7:0] c);
		offer(stb_pkg::OP_BYTE, c);
	endtask

	// ---- token builders -----------------------------------------------------

	task automatic put_word_tok(input int n);
		feed(pick_letter());
		repeat (n - 1) feed(pick_alnum());
	endtask

	task automatic put_number(input int n_int, input bit dot, input int n_frac);
		repeat (n_int) feed(pick_digit());
		if (dot) begin
			feed(stb_pkg::CH_DOT);
			repeat (n_frac) feed(pick_digit());
		end
	endtask

	task automatic put_string(input int n);
		feed(stb_pkg::CH_QUOTE);
		repeat (n) feed(pick_free(1'b1));
		feed(stb_pkg::CH_QUOTE);
	endtask

	task automatic put_comment(input int n);
		feed(stb_pkg::CH_HASH);
		repeat (n) feed(pick_free(1'b0));
		feed(stb_pkg::CH_NL);
	endtask

	// Numbers over the cap are plain digits: the cap then splits them into
	// two numbers. A dot right at the cap would be an unexpected character.
	task automatic random_number();
		if ($urandom_range(0, 19) == 0)
			put_number($urandom_range(60, 70), 1'b0, 0);
		else
			put_number($urandom_range(1, 5), 1'($urandom_range(0, 1)), $urandom_range(0, 4));
	endtask

	// One random token. Words and numbers are closed by a blank so that a
	// following number cannot run into a second dot; numbers running straight
	// into a word, and bare trailing dots, are left in on purpose.
	task automatic random_token();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			put_word_tok(($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
				: $urandom_range(1, 8));
			feed(pick_blank());
		end else if (pick < 44) begin
			random_number();
			feed(pick_blank());
		end else if (pick < 50) begin
			random_number();
			put_word_tok($urandom_range(1, 4));
			feed(pick_blank());
		end else if (pick < 62) begin
			put_string(($urandom_range(0, 11) == 0) ? $urandom_range(60, TOK_CAP - 1)
				: $urandom_range(0, 8));
		end else if (pick < 72) begin
			put_comment($urandom_range(0, 10));
		end else if (pick < 84) begin
			feed(stb_pkg::CH_NL);
		end else begin
			repeat ($urandom_range(1, 3)) feed(pick_blank());
		end
	endtask

	task automatic finish_source();
		ending_t how;
		how = ending_t'($urandom_range(0, 7));
		case (how)
			END_BARE: begin
				offer(stb_pkg::OP_END, 8'($urandom));
			end
			END_AFTER_WORD: begin
				put_word_tok(2);
				offer(stb_pkg::OP_END, 8'($urandom));
			end
			END_AFTER_NL: begin
				feed(stb_pkg::CH_NL);
				offer(stb_pkg::OP_END, 8'($urandom));
			end
			END_STRAY: begin
				if ($urandom_range(0, 1) == 1) put_word_tok(2);
				feed(strays[$urandom_range(0, strays.size() - 1)]);
			end
			END_SECOND_DOT: begin
				put_number(1, 1'b1, 1);
				feed(stb_pkg::CH_DOT);
			end
			END_STR_NL: begin
				feed(stb_pkg::CH_QUOTE);
				repeat (2) feed(pick_free(1'b1));
				feed(stb_pkg::CH_NL);
			end
			END_STR_EOF: begin
				feed(stb_pkg::CH_QUOTE);
				repeat (2) feed(pick_free(1'b1));
				offer(stb_pkg::OP_END, 8'($urandom));
			end
			default: begin
				// cap full, then one more text byte
				feed(stb_pkg::CH_QUOTE);
				repeat (TOK_CAP) feed(pick_free(1'b1));
			end
		endcase
	endtask

	// ---- stimulus and verdict -----------------------------------------------

	initial begin
		arst_n    <= 1'b0;
		src.valid <= 1'b0;
		src.op    <= stb_pkg::OP_BYTE;
		src.ch    <= 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) feed(opening[i]);
		while (sent < opening.size() + RAND_WORDS) random_token();

		// full-rate runs: blanks, then newlines
		rush = 1'b1;
		repeat (SAT_RUN) feed(stb_pkg::CH_SPACE);
		put_word_tok(3);
		feed(stb_pkg::CH_NL);
		repeat (SAT_RUN) feed(stb_pkg::CH_NL);
		put_word_tok(2);
		feed(stb_pkg::CH_SPACE);
		rush = 1'b0;

		finish_source();
		// all of these must be dropped by the block, stopped at end of file or an error
		repeat (12) offer(1'($urandom_range(0, 1)), 8'($urandom));
		src.valid <= 1'b0;

		// due count is registered, so it trails the checker's queue
		@(posedge clk);
		while (due_cnt != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && due_cnt == 0)
			$display("source_tokenizer: match");
		else
			$display("source_tokenizer: mismatch");
		$finish;
	end

	// ---- token channel ------------------------------------------------------

	// Random ready gaps per word, quiet stretches, and two long hold-offs
	// during the random part while the source keeps offering, so the
	// four-entry queue fills and src.ready drops.
	initial begin
		int gap;
		int taken;
		bit quiet;
		taken = 0;
		quiet = 1'b0;
		tok.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == 250 || taken == 700) begin
				tok.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = (rush || quiet) ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				tok.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tok.ready <= 1'b1;
			@(posedge clk);
			while (!tok.valid) @(posedge clk);
			taken++;
			if (taken % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
		end
	end

	// ---- watchdog -----------------------------------------------------------

	// Longest legal stall is the sink hold-off; anything far past it is a hang.
	initial begin
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((src.valid && src.ready) || (tok.valid && tok.ready))
				idle = 0;
			else
				idle++;
		end
		$display("source_tokenizer: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
rtl/stb_pkg.sv
rtl/stb_in_if.sv
rtl/stb_out_if.sv
rtl/stb_front.sv
rtl/stb_queue.sv
rtl/stb_back.sv
rtl/source_tokenizer.sv
tb/source_tokenizer_chk.sv
tb/source_tokenizer_tb.sv
